// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

    // Default number of slots in the ring.
    localparam int DQ_DEPTH = 16;

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes; every other code lists the queue.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/dq_ram.sv =====
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Channel   Signals                       Direction  Handshake
// command   cmd, value                    in         accepted when start && !busy
// result    status, item, last            out        one beat per cycle where strobe is high
//
// A push or a pop never raises busy: a new command can be accepted every cycle while
// no listing runs, and its single result beat appears on the cycle after acceptance.
// A listing of n entries holds busy until the read of its last entry is issued and emits
// n beats on consecutive cycles; the single read port of the entry RAM sets this.
// Reset clears the front slot and the occupancy; the entry RAM is not cleared.
// The receiver cannot stall: every result beat is taken in the cycle it appears.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [dq_pkg::CMD_W-1:0]            cmd,
    input  logic signed [dq_pkg::DATA_W-1:0]    value,
    output logic                                busy,
    output logic                                strobe,
    output logic [dq_pkg::STATUS_W-1:0]         status,
    output logic signed [dq_pkg::DATA_W-1:0]    item,
    output logic                                last
);

    import dq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] WRAP     = SUM_W'(DEPTH);

    // Queue state and listing sequencer.
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    list_slot_reg, list_slot_next;
    logic [CNT_W-1:0]    list_left_reg, list_left_next;
    logic                busy_reg, busy_next;

    // Result beat registers.
    logic                strobe_reg, strobe_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                last_reg, last_next;
    logic                use_ram_reg, use_ram_next;

    // RAM port signals.
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    // Decoded command and ring arithmetic.
    logic                accept;
    logic                is_push;
    logic                is_pop;
    logic                is_empty;
    logic                is_full;
    logic [IDX_W-1:0]    front_prev;
    logic [IDX_W-1:0]    front_succ;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_slot;
    logic [IDX_W-1:0]    rear_slot;
    logic [IDX_W-1:0]    list_slot_succ;

    assign accept   = start && !busy_reg;
    assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
    assign is_pop   = (cmd == CMD_POP_FRONT) || (cmd == CMD_POP_REAR);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);

    // Neighbor slots of the front entry.
    assign front_prev = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_succ = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;

    // The slot just behind the rear entry, and the rear entry itself.
    assign tail_sum  = {1'b0, front_reg} + SUM_W'(count_reg);
    assign tail_slot = (tail_sum >= WRAP) ? IDX_W'(tail_sum - WRAP) : IDX_W'(tail_sum);
    assign rear_slot = (tail_slot == '0) ? LAST_IDX : tail_slot - 1'b1;

    assign list_slot_succ = (list_slot_reg == LAST_IDX) ? '0 : list_slot_reg + 1'b1;

    // Command decode, state update and RAM access.
    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        list_slot_next = list_slot_reg;
        list_left_next = list_left_reg;
        busy_next      = busy_reg;
        strobe_next    = 1'b0;
        status_next    = ST_OK;
        last_next      = 1'b1;
        use_ram_next   = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = tail_slot;
        mem_wdata      = value;
        mem_re         = 1'b0;
        mem_raddr      = front_reg;

        if (busy_reg)
        begin
            // Listing in progress: read the next entry toward the rear.
            mem_re         = 1'b1;
            mem_raddr      = list_slot_reg;
            list_slot_next = list_slot_succ;
            list_left_next = list_left_reg - 1'b1;
            busy_next      = (list_left_reg != CNT_W'(1));
            strobe_next    = 1'b1;
            use_ram_next   = 1'b1;
            last_next      = (list_left_reg == CNT_W'(1));
        end
        else if (accept)
        begin
            strobe_next = 1'b1;
            priority if (is_push)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        mem_waddr  = front_prev;
                        front_next = front_prev;
                    end
                end
            end
            else if (is_pop)
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_re       = 1'b1;
                    use_ram_next = 1'b1;
                    count_next   = count_reg - 1'b1;
                    if (cmd == CMD_POP_FRONT)
                    begin
                        mem_raddr  = front_reg;
                        front_next = front_succ;
                    end
                    else
                    begin
                        mem_raddr = rear_slot;
                    end
                end
            end
            else
            begin
                // Listing, also taken for the unused codes.
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = front_reg;
                    use_ram_next   = 1'b1;
                    list_slot_next = front_succ;
                    list_left_next = count_reg - 1'b1;
                    busy_next      = (count_reg != CNT_W'(1));
                    last_next      = (count_reg == CNT_W'(1));
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            list_slot_reg <= '0;
            list_left_reg <= '0;
            busy_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
            use_ram_reg   <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            list_slot_reg <= list_slot_next;
            list_left_reg <= list_left_next;
            busy_reg      <= busy_next;
            strobe_reg    <= strobe_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
            use_ram_reg   <= use_ram_next;
        end
    end

    // Entry storage.
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_dq_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result beat; the item comes straight from the RAM read register.
    assign busy   = busy_reg;
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign last   = last_reg;
    assign item   = use_ram_reg ? signed'(mem_rdata) : '0;

`ifndef SYNTH
    // Occupancy never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy above ring size");

    // No write lands while a listing walks the ring.
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !mem_we)
        else $error("RAM write during listing");

    // A push or pop gives exactly one beat, marked last, on the next cycle.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (is_push || is_pop)) |=> (strobe && last))
        else $error("push or pop beat missing");

    // The queue is left unchanged while a listing runs.
    a_list_stable: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> ($stable(count_reg) && $stable(front_reg)))
        else $error("queue changed during listing");

    // A listing step left in flight always has a beat to deliver.
    a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (strobe && use_ram_reg))
        else $error("listing step produced no beat");
`endif

endmodule

// ===== tb/dq_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and result channels of the deque, keeps its own copy of
// the ring and checks every result beat against the oldest predicted beat.
module dq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [dq_pkg::CMD_W-1:0]          cmd,
    input  logic signed [dq_pkg::DATA_W-1:0]  value,
    input  logic                              strobe,
    input  logic [dq_pkg::STATUS_W-1:0]       status,
    input  logic signed [dq_pkg::DATA_W-1:0]  item,
    input  logic                              last,
    output int                                fail_count,
    output int                                beats_owed
);

    import dq_pkg::*;

    localparam int SLOT_W = $clog2(DQ_DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] item;
        logic                     last;
    } beat_t;

    // Shadow copy of the ring: entries, slot of the front entry, entry count.
    logic signed [DATA_W-1:0] ring_slots [DQ_DEPTH];
    logic [SLOT_W-1:0]        front_slot;
    logic [SLOT_W:0]          fill;

    // Result beats predicted but not yet seen, oldest first.
    beat_t owed_beats [$];

    // Slot that lies a given number of entries behind the front.
    function automatic logic [SLOT_W-1:0] slot_at(int offset);
        return SLOT_W'((int'(front_slot) + offset) % DQ_DEPTH);
    endfunction

    // Applies one accepted command to the shadow ring and queues its beats.
    function void apply_command(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
        logic [SLOT_W-1:0] slot;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (fill == DQ_DEPTH)
                begin
                    owed_beats.push_back('{ST_FULL, '0, 1'b1});
                end
                else
                begin
                    if (c == CMD_PUSH_FRONT)
                    begin
                        front_slot = slot_at(DQ_DEPTH - 1);
                        ring_slots[front_slot] = v;
                    end
                    else
                    begin
                        ring_slots[slot_at(int'(fill))] = v;
                    end
                    fill = fill + 1'b1;
                    owed_beats.push_back('{ST_OK, '0, 1'b1});
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (fill == 0)
                begin
                    owed_beats.push_back('{ST_EMPTY, '0, 1'b1});
                end
                else
                begin
                    if (c == CMD_POP_FRONT)
                    begin
                        slot = front_slot;
                        front_slot = slot_at(1);
                    end
                    else
                    begin
                        slot = slot_at(int'(fill) - 1);
                    end
                    fill = fill - 1'b1;
                    owed_beats.push_back('{ST_OK, ring_slots[slot], 1'b1});
                end
            end
            default:
            begin
                // Listing, also for the unused codes: one beat per entry.
                if (fill == 0)
                begin
                    owed_beats.push_back('{ST_EMPTY, '0, 1'b1});
                end
                else
                begin
                    for (int i = 0; i < int'(fill); i++)
                    begin
                        owed_beats.push_back('{ST_OK, ring_slots[slot_at(i)],
                                               (i + 1 == int'(fill))});
                    end
                end
            end
        endcase
    endfunction

    // Check the result beat of this edge first, since a command accepted at
    // the same edge cannot have caused it, then take in the new command.
    always @(posedge clk)
    begin
        beat_t want;
        if (!rst_n)
        begin
            front_slot = '0;
            fill = '0;
            owed_beats.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (owed_beats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result beat status=%0d item=%0d last=%0b",
                                 $time, status, item, last);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (status !== want.status || item !== want.item || last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result mismatch: expected status=%0d item=%0d ",
                                      "last=%0b, got status=%0d item=%0d last=%0b"},
                                     $time, want.status, want.item, want.last,
                                     status, item, last);
                    end
                end
            end
            if (start && !busy)
                apply_command(cmd, value);
        end
        beats_owed = owed_beats.size();
    end

endmodule

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 100ps

module double_ended_queue_test;

    import dq_pkg::*;

    localparam int RANDOM_ITEMS = 310;
    localparam int QUIET_TAIL   = 60;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic                     busy;
    logic                     strobe;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item;
    logic                     last;

    int fail_count;
    int beats_owed;
    int sent;
    bit gaps_on;

    double_ended_queue DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .value  (value),
        .busy   (busy),
        .strobe (strobe),
        .status (status),
        .item   (item),
        .last   (last)
    );

    dq_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .value      (value),
        .strobe     (strobe),
        .status     (status),
        .item       (item),
        .last       (last),
        .fail_count (fail_count),
        .beats_owed (beats_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drives one command beat and holds it until the block takes it, then
    // sometimes leaves a short gap before the next one.
    task automatic issue(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v);
        start <= 1'b1;
        cmd   <= c;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            cmd   <= CMD_W'($urandom);
            value <= DATA_W'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Mostly random data, now and then one of the corner values.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_push();
        return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    endfunction

    function automatic logic [CMD_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    endfunction

    // Listing code, including the unused codes that also list.
    function automatic logic [CMD_W-1:0] pick_list();
        return $urandom_range(0, 1) ? CMD_LIST : CMD_W'($urandom_range(CMD_LIST, 7));
    endfunction

    initial
    begin
        int guard;
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = CMD_PUSH_FRONT;
        value   = '0;
        sent    = 0;
        gaps_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, corner values at both ends, all listing codes.
        issue(CMD_LIST, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_REAR, '0);
        issue(CMD_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}});
        issue(CMD_PUSH_REAR, {1'b1, {(DATA_W-1){1'b0}}});
        issue(CMD_PUSH_FRONT, '1);
        issue(CMD_PUSH_REAR, '0);
        issue(CMD_LIST, '1);
        issue(CMD_W'(5), '0);
        issue(CMD_W'(6), '0);
        issue(CMD_W'(7), '0);
        issue(CMD_POP_FRONT, '1);
        issue(CMD_POP_REAR, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_REAR, '0);
        issue(CMD_LIST, '0);

        // Random: fill-to-full runs, drain-to-empty runs and mixed traffic.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            gaps_on = (sent < RANDOM_ITEMS - QUIET_TAIL);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // More pushes than slots, so the queue always ends up full.
                    repeat (DQ_DEPTH + $urandom_range(1, 2)) issue(pick_push(), pick_value());
                    issue(pick_list(), pick_value());
                end
                2, 3:
                begin
                    repeat (DQ_DEPTH + $urandom_range(1, 2))
                    begin
                        if ($urandom_range(0, 7) == 0)
                            issue(pick_list(), pick_value());
                        else
                            issue(pick_pop(), pick_value());
                    end
                end
                default:
                begin
                    repeat (8)
                    begin
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5, 6, 7:  issue(pick_push(), pick_value());
                            8, 9, 10, 11, 12, 13, 14: issue(pick_pop(), pick_value());
                            default:                 issue(pick_list(), pick_value());
                        endcase
                    end
                end
            endcase
        end
        start <= 1'b0;

        // Drain: wait for every owed beat, then a few quiet cycles.
        guard = 0;
        while (beats_owed != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DQ_DEPTH + 4) @(posedge clk);

        if (fail_count == 0 && beats_owed == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #1000000;
        $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule
